// File: sv/brf_pkg.sv
// Shared constants, codes and control structs for the byte ring FIFO.
package brf_pkg;

    localparam int MAX_DEPTH   = 256;
    localparam int MAX_REQUEST = 64;
    localparam int IDX_W       = $clog2(MAX_DEPTH);
    localparam int LVL_W       = $clog2(MAX_DEPTH + 1);
    localparam int REQ_W       = 7;
    localparam int FUNC_W      = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] STAT_EMPTY = 2'd0;
    localparam logic [1:0] STAT_PART  = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Command from the controller to the datapath for one result word.
    typedef struct packed {
        logic load;    // load the output register this cycle
        logic put;     // store the input byte if there is room
        logic read;    // read one byte and advance the read index
        logic clear;   // reset indices and mirror bits
        logic last;    // final word of this item
    } brf_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic             out_free;  // output register can take a word
        logic [LVL_W-1:0] fill;      // bytes currently held
    } brf_stat_t;

endpackage

// File: sv/brf_ctrl.sv
// Controller state machine: accepts items and sequences the bytes of a get.
module brf_ctrl
    import brf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [REQ_W-1:0]  request_length,
    input  brf_stat_t         stat,
    output brf_cmd_t          cmd
);

    typedef enum logic {IDLE, GET} state_t;

    state_t           state_reg, state_next;
    logic [REQ_W-1:0] rem_reg, rem_next;

    logic [LVL_W-1:0] req_sat;
    logic [LVL_W-1:0] count;
    logic             accept;

    assign in_ready = (state_reg == IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        req_sat = (request_length > REQ_W'(MAX_REQUEST)) ? LVL_W'(MAX_REQUEST)
                                                         : LVL_W'(request_length);
        count   = (req_sat < stat.fill) ? req_sat : stat.fill;
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    cmd.last = 1'b1;
                    case (func)
                        FUNC_PUT:   cmd.put   = 1'b1;
                        FUNC_CLEAR: cmd.clear = 1'b1;
                        FUNC_GET:
                        begin
                            if (count != '0)
                            begin
                                cmd.read = 1'b1;
                                if (count != LVL_W'(1))
                                begin
                                    // more bytes follow: stream the rest
                                    cmd.last   = 1'b0;
                                    rem_next   = REQ_W'(count - LVL_W'(1));
                                    state_next = GET;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            GET:
            begin
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.read = 1'b1;
                    cmd.last = (rem_reg == REQ_W'(1));
                    rem_next = rem_reg - REQ_W'(1);
                    if (rem_reg == REQ_W'(1))
                        state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
        end
    end

`ifndef SYNTHESIS
    a_get_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == GET |-> rem_reg != '0)
        else $error("get sequence running with no bytes left");
`endif

endmodule

// File: sv/brf_dp.sv
// Datapath: byte store, ring indices with mirror bits, levels and output register.
module brf_dp
    import brf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  brf_cmd_t         cmd,
    output brf_stat_t        stat,
    input  logic [7:0]       data_in,
    input  logic             cfg_we,
    input  logic [LVL_W-1:0] cfg_capacity,
    output logic [LVL_W-1:0] capacity,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [7:0]       data_out,
    output logic             data_valid,
    output logic             accepted,
    output logic             last,
    output logic [LVL_W-1:0] fill_level,
    output logic [LVL_W-1:0] free_space,
    output logic [1:0]       status
);

    logic [7:0]       store [MAX_DEPTH];

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             wr_mir_reg, wr_mir_next;
    logic             rd_mir_reg, rd_mir_next;
    logic [LVL_W-1:0] fill_reg, fill_next;
    logic [LVL_W-1:0] cap_reg;

    logic             out_valid_reg;
    logic [7:0]       data_reg;
    logic             dvalid_reg, acc_reg, last_reg;
    logic [LVL_W-1:0] lvl_reg, free_reg;
    logic [1:0]       status_reg;

    logic             full;
    logic             put_ok;
    logic             wr_wrap, rd_wrap;

    assign full    = (wr_idx_reg == rd_idx_reg) && (wr_mir_reg != rd_mir_reg);
    assign put_ok  = cmd.put && !full;
    assign wr_wrap = ({1'b0, wr_idx_reg} + LVL_W'(1)) >= cap_reg;
    assign rd_wrap = ({1'b0, rd_idx_reg} + LVL_W'(1)) >= cap_reg;

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.fill     = fill_reg;

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        wr_mir_next = wr_mir_reg;
        rd_mir_next = rd_mir_reg;
        fill_next   = fill_reg;
        if (cmd.clear)
        begin
            wr_idx_next = '0;
            rd_idx_next = '0;
            wr_mir_next = 1'b1;
            rd_mir_next = 1'b1;
            fill_next   = '0;
        end
        else if (put_ok)
        begin
            wr_idx_next = wr_wrap ? '0 : wr_idx_reg + IDX_W'(1);
            wr_mir_next = wr_mir_reg ^ wr_wrap;
            fill_next   = fill_reg + LVL_W'(1);
        end
        else if (cmd.read)
        begin
            rd_idx_next = rd_wrap ? '0 : rd_idx_reg + IDX_W'(1);
            rd_mir_next = rd_mir_reg ^ rd_wrap;
            fill_next   = fill_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            wr_mir_reg <= 1'b1;
            rd_mir_reg <= 1'b1;
            fill_reg   <= '0;
            cap_reg    <= LVL_W'(MAX_DEPTH);
        end
        else if (cfg_we)
        begin
            // new capacity: drop everything held
            cap_reg    <= cfg_capacity;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            wr_mir_reg <= 1'b1;
            rd_mir_reg <= 1'b1;
            fill_reg   <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            wr_mir_reg <= wr_mir_next;
            rd_mir_reg <= rd_mir_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put_ok)
            store[wr_idx_reg] <= data_in;
    end

    // Output register; the byte field doubles as the store's read register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (cmd.read)
                data_reg <= store[rd_idx_reg];
            else
                data_reg <= '0;
            dvalid_reg <= cmd.read;
            acc_reg    <= put_ok;
            last_reg   <= cmd.last;
            lvl_reg    <= fill_next;
            free_reg   <= cap_reg - fill_next;
            if (fill_next == '0)
                status_reg <= STAT_EMPTY;
            else if (fill_next >= cap_reg)
                status_reg <= STAT_FULL;
            else
                status_reg <= STAT_PART;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign capacity   = cap_reg;
    assign out_valid  = out_valid_reg;
    assign data_out   = data_reg;
    assign data_valid = dvalid_reg;
    assign accepted   = acc_reg;
    assign last       = last_reg;
    assign fill_level = lvl_reg;
    assign free_space = free_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap_reg)
        else $error("fill level above capacity");

    a_mirror_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) == ((wr_idx_reg == rd_idx_reg) && (wr_mir_reg == rd_mir_reg)))
        else $error("fill count disagrees with mirror-bit empty");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wr_idx_reg} < cap_reg) && ({1'b0, rd_idx_reg} < cap_reg))
        else $error("ring index at or above capacity");
`endif

endmodule

// File: sv/byte_ring_fifo_mirror.sv
// Top level of the byte ring FIFO: stream channels, APB register port, wiring.
//
// Byte FIFO over a ring store of up to 256 slots, with mirror bits for full/empty.
// Input words (s_*): s_tuser selects the operation (put, get, clear), s_tdata
// carries the byte to put and the length requested by a get.
// Output words (m_*): one word per put, clear or unused code, and one word per
// byte for a get (min of request, capped at 64, and fill; one word marked not
// valid if that is zero). m_tlast marks the final word of an item.
// Each word reports fill level, free space and status after its step.
// The first word of an item appears in the cycle after the item is accepted.
// A get streams its bytes one byte per cycle while the receiver does not stall,
// through the single read port of the store.
// A new item is taken only after the previous one has issued all its words,
// and only when the output register is empty or its word leaves in that cycle.
// If the receiver stalls, the output register holds and the block pauses.
// Reset: empty buffer, capacity 256. The capacity register (address 0) takes
// 1..256 (pwdata[8:0] of 0 reads as 1, larger as 256); writing it empties the buffer.
module byte_ring_fifo_mirror
    import brf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_in[7:0], request_length[14:8], zero[15]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_out[7:0], fill_level[16:8],
                                   // free_space[25:17], status[27:26], zero[31:28]
    output logic [1:0]  m_tuser,   // data_valid[0], accepted[1]
    output logic        m_tlast
);

    brf_cmd_t         cmd;
    brf_stat_t        stat;
    logic             cfg_we;
    logic [LVL_W-1:0] cfg_raw;
    logic [LVL_W-1:0] cfg_capacity;
    logic [LVL_W-1:0] capacity;
    logic [7:0]       data_out;
    logic [LVL_W-1:0] fill_level;
    logic [LVL_W-1:0] free_space;
    logic [1:0]       status;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
    assign cfg_raw = pwdata[LVL_W-1:0];

    always_comb
    begin
        if (cfg_raw == '0)
            cfg_capacity = LVL_W'(1);
        else if (cfg_raw > LVL_W'(MAX_DEPTH))
            cfg_capacity = LVL_W'(MAX_DEPTH);
        else
            cfg_capacity = cfg_raw;
    end

    assign prdata = paddr[2] ? '0 : {{(32-LVL_W){1'b0}}, capacity};

    brf_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .func           (s_tuser),
        .request_length (s_tdata[14:8]),
        .stat           (stat),
        .cmd            (cmd)
    );

    brf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .data_in      (s_tdata[7:0]),
        .cfg_we       (cfg_we),
        .cfg_capacity (cfg_capacity),
        .capacity     (capacity),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .data_out     (data_out),
        .data_valid   (m_tuser[0]),
        .accepted     (m_tuser[1]),
        .last         (m_tlast),
        .fill_level   (fill_level),
        .free_space   (free_space),
        .status       (status)
    );

    assign m_tdata = {4'b0, status, free_space, fill_level, data_out};

endmodule

// File: tb/sv/testbench.sv
// Testbench for the byte ring FIFO: stream driver, word monitor, ring predictor, APB setup.
module testbench
    import brf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_NOP      = 2'd3;
    localparam logic [2:0]        ADDR_CAPACITY = 3'd0;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [7:0]        din;
        logic [REQ_W-1:0]  req;
    } fifo_op_t;

    typedef struct {
        logic [7:0]       data;
        logic             valid;
        logic             acc;
        logic             last;
        logic [LVL_W-1:0] fill;
        logic [LVL_W-1:0] free;
        logic [1:0]       stat;
    } fifo_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // data_in[7:0], request_length[14:8], zero[15]
    logic [1:0]  s_tuser = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // data_out[7:0], fill_level[16:8], free_space[25:17],
                                 // status[27:26], zero[31:28]
    logic [1:0]  m_tuser;        // data_valid[0], accepted[1]
    logic        m_tlast;

    byte_ring_fifo_mirror i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ring predictor state
    logic [7:0]       ring_mem [MAX_DEPTH];
    logic [IDX_W-1:0] wr_idx = '0;
    logic [IDX_W-1:0] rd_idx = '0;
    bit               wr_mir = 1'b1;
    bit               rd_mir = 1'b1;
    logic [LVL_W-1:0] ring_cap = LVL_W'(MAX_DEPTH);

    fifo_op_t   op_queue [$];
    fifo_word_t due_words [$];
    fifo_op_t   cur_op;
    int         errors = 0;
    bit         calm = 1'b0;     // no idling on either side
    bit         squeeze = 1'b0;  // request one long receiver hold-off
    bit         hold_done = 1'b0;
    int         hold_left = 0;

    function automatic logic [LVL_W-1:0] ring_fill();
        if (wr_idx == rd_idx)
            return (wr_mir == rd_mir) ? '0 : ring_cap;
        if (wr_idx > rd_idx)
            return LVL_W'(wr_idx) - LVL_W'(rd_idx);
        return ring_cap - (LVL_W'(rd_idx) - LVL_W'(wr_idx));
    endfunction

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx, inout bit mir);
        if (int'(idx) + 1 >= int'(ring_cap))
        begin
            mir = ~mir;
            return '0;
        end
        return idx + IDX_W'(1);
    endfunction

    function automatic void ring_clear();
        wr_idx = '0;
        rd_idx = '0;
        wr_mir = 1'b1;
        rd_mir = 1'b1;
    endfunction

    function automatic void ring_set_cap(input logic [LVL_W-1:0] val);
        if (val == 0)
            ring_cap = LVL_W'(1);
        else if (val > MAX_DEPTH)
            ring_cap = LVL_W'(MAX_DEPTH);
        else
            ring_cap = val;
        ring_clear();
    endfunction

    function automatic void ring_push_word(input logic [7:0] d, input bit v, input bit a,
                                           input bit l);
        fifo_word_t       w;
        logic [LVL_W-1:0] f;
        f = ring_fill();
        w.data  = d;
        w.valid = v;
        w.acc   = a;
        w.last  = l;
        w.fill  = f;
        w.free  = ring_cap - f;
        w.stat  = (f == 0) ? STAT_EMPTY : ((f >= ring_cap) ? STAT_FULL : STAT_PART);
        due_words.push_back(w);
    endfunction

    function automatic void ring_apply(input fifo_op_t op);
        int         n;
        bit         ok;
        logic [7:0] b;
        case (op.func)
            FUNC_PUT:
            begin
                ok = 1'b0;
                if (ring_fill() < ring_cap)
                begin
                    ring_mem[wr_idx] = op.din;
                    wr_idx = ring_next(wr_idx, wr_mir);
                    ok = 1'b1;
                end
                ring_push_word(8'h00, 1'b0, ok, 1'b1);
            end
            FUNC_GET:
            begin
                n = (op.req > MAX_REQUEST) ? MAX_REQUEST : int'(op.req);
                if (int'(ring_fill()) < n)
                    n = int'(ring_fill());
                if (n == 0)
                    ring_push_word(8'h00, 1'b0, 1'b0, 1'b1);
                for (int i = 0; i < n; i++)
                begin
                    b = ring_mem[rd_idx];
                    rd_idx = ring_next(rd_idx, rd_mir);
                    ring_push_word(b, 1'b1, 1'b0, i == n - 1);
                end
            end
            FUNC_CLEAR:
            begin
                ring_clear();
                ring_push_word(8'h00, 1'b0, 1'b0, 1'b1);
            end
            default:
                ring_push_word(8'h00, 1'b0, 1'b0, 1'b1);
        endcase
    endfunction

    function automatic void flag(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // sender: predict on acceptance, then offer the next pending word or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                ring_apply(cur_op);
            if (!s_tvalid || s_tready)
            begin
                if (op_queue.size() > 0 && (calm || $urandom_range(99) >= 26))
                begin
                    cur_op = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cur_op.req, cur_op.din};
                    s_tuser  <= cur_op.func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: check each word against the oldest prediction, then choose ready
    always @(posedge clk)
    begin
        fifo_word_t w;
        fifo_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.data  = m_tdata[7:0];
            got.fill  = m_tdata[16:8];
            got.free  = m_tdata[25:17];
            got.stat  = m_tdata[27:26];
            got.valid = m_tuser[0];
            got.acc   = m_tuser[1];
            got.last  = m_tlast;
            if (due_words.size() == 0)
                flag($sformatf("unexpected word data=%h fill=%0d", got.data, got.fill));
            else
            begin
                w = due_words.pop_front();
                if (got.data !== w.data || got.valid !== w.valid || got.acc !== w.acc ||
                    got.last !== w.last || got.fill !== w.fill || got.free !== w.free ||
                    got.stat !== w.stat || m_tdata[31:28] !== 4'h0)
                    flag($sformatf({"word mismatch: exp data=%h v=%b a=%b l=%b fill=%0d ",
                                    "free=%0d st=%0d, got data=%h v=%b a=%b l=%b fill=%0d ",
                                    "free=%0d st=%0d top=%h"},
                                   w.data, w.valid, w.acc, w.last, w.fill, w.free, w.stat,
                                   got.data, got.valid, got.acc, got.last, got.fill,
                                   got.free, got.stat, m_tdata[31:28]));
            end
        end
        if (squeeze && !hold_done)
        begin
            hold_left = 300;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || $urandom_range(99) >= 26;
    end

    task automatic enqueue(input logic [FUNC_W-1:0] func, input logic [7:0] din,
                           input logic [REQ_W-1:0] req);
        fifo_op_t op;
        op.func = func;
        op.din  = din;
        op.req  = req;
        op_queue.push_back(op);
    endtask

    task automatic enqueue_random();
        int r;
        int rl;
        r  = $urandom_range(99);
        rl = $urandom_range(99);
        if (r < 50)
            enqueue(FUNC_PUT, 8'($urandom_range(255)), 7'($urandom_range(127)));
        else if (r < 85)
            enqueue(FUNC_GET, 8'($urandom_range(255)),
                    rl < 70 ? 7'($urandom_range(8, 1)) :
                    rl < 85 ? 7'($urandom_range(64, 9)) :
                    rl < 93 ? 7'($urandom_range(127, 65)) : 7'd0);
        else if (r < 93)
            enqueue(FUNC_CLEAR, 8'($urandom_range(255)), 7'($urandom_range(127)));
        else
            enqueue(FUNC_NOP, 8'($urandom_range(255)), 7'($urandom_range(127)));
    endtask

    // hold until every pending word is sent and every predicted word has come back;
    // sample between edges so the driver and monitor have settled
    task automatic drain();
        while (op_queue.size() > 0 || s_tvalid || due_words.size() > 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [LVL_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= {23'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        ring_set_cap(val);
        // read back the clamped value
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== {23'd0, ring_cap})
            flag($sformatf("capacity readback: exp %0d, got %0d", ring_cap, prdata));
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [LVL_W-1:0] cap_plan [8];
        cap_plan = '{9'd1, 9'd2, 9'd0, 9'd3, 9'd7, 9'd300, 9'd16, 9'd40};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset capacity: empty get, unused code, zero and oversized requests
        enqueue(FUNC_GET, 8'h00, 7'd5);
        enqueue(FUNC_NOP, 8'hFF, 7'h7F);
        enqueue(FUNC_PUT, 8'h00, 7'd0);
        enqueue(FUNC_GET, 8'h00, 7'd0);
        enqueue(FUNC_PUT, 8'hFF, 7'h7F);
        enqueue(FUNC_GET, 8'h00, 7'd127);
        drain();

        // small ring: fill, drop on full, wrap both indices, clear
        set_capacity(9'd4);
        enqueue(FUNC_PUT, 8'hFF, 7'd0);
        enqueue(FUNC_PUT, 8'hA5, 7'd0);
        enqueue(FUNC_PUT, 8'h5A, 7'd0);
        enqueue(FUNC_PUT, 8'h3C, 7'd0);
        enqueue(FUNC_PUT, 8'h11, 7'd0);
        enqueue(FUNC_NOP, 8'h00, 7'd0);
        enqueue(FUNC_GET, 8'h00, 7'd1);
        enqueue(FUNC_PUT, 8'h22, 7'd0);
        enqueue(FUNC_GET, 8'h00, 7'd127);
        enqueue(FUNC_GET, 8'h00, 7'd3);
        enqueue(FUNC_PUT, 8'h77, 7'd0);
        enqueue(FUNC_CLEAR, 8'h00, 7'd0);
        enqueue(FUNC_GET, 8'h00, 7'd2);
        enqueue(FUNC_PUT, 8'h80, 7'd0);
        enqueue(FUNC_PUT, 8'h01, 7'd0);
        enqueue(FUNC_GET, 8'h00, 7'd64);
        drain();

        foreach (cap_plan[p])
        begin
            set_capacity(p == 7 ? 9'($urandom_range(64, 1)) : cap_plan[p]);
            calm    = (p == 4);
            squeeze = squeeze || (p == 5);
            repeat (15) enqueue_random();
            drain();
        end
        calm = 1'b0;

        // oversized capacity write clamps to the largest ring
        set_capacity(9'd511);
        repeat (8) enqueue_random();
        drain();

        if (errors == 0 && due_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
